[src/cdq_pkg.sv]
// ============================================================================
// cdq_pkg
// Shared sizes, codes, types and index helpers for the circular deque block.
// ============================================================================
package cdq_pkg;

    // Ring store geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths on the ports
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam int ACT_W     = 3;
    localparam int VAL_W     = 32;

    // Stream packing: fields packed from bit 0 up, padded to whole bytes
    localparam int S_FIELDS_W = ACT_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + VAL_W + VAL_W + 1 + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY     = 3'd0,
        ACT_INS_FRONT = 3'd1,
        ACT_INS_REAR  = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_REAR  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;   // capture the input transfer
        logic exec;   // apply the action to indices and ring store
        logic load;   // capture the result into the output register
    } cdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds a result not yet taken
    } cdq_status_t;

    // Step an index forward, wrapping at the capacity
    function automatic idx_t idx_next(idx_t i, cnt_t cap);
        cnt_t inc;
        inc = cnt_t'(i) + cnt_t'(1);
        if (inc >= cap) begin
            return '0;
        end
        return idx_t'(inc);
    endfunction

    // Step an index backward, wrapping at the capacity
    function automatic idx_t idx_prev(idx_t i, cnt_t cap);
        if (i == '0 || cnt_t'(i) >= cap) begin
            return idx_t'(cap - cnt_t'(1));
        end
        return i - idx_t'(1);
    endfunction

endpackage

[src/cdq_ram.sv]
// ============================================================================
// cdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                      rd_data_a,
    output logic [WIDTH-1:0]                      rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register both reads
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[src/cdq_ctrl.sv]
// ============================================================================
// cdq_ctrl
// Sequencer: take one transfer, apply it, read the ring, load the result.
// ============================================================================
module cdq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cdq_pkg::cdq_status_t status,
    output cdq_pkg::cdq_cmd_t    cmd
);
    import cdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/cdq_datapath.sv]
// ============================================================================
// cdq_datapath
// Head/tail indices, empty flag, capacity register, ring store and the
// output register.
// ============================================================================
module cdq_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]       cfg_wr_data,
    input  logic [cdq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  cdq_pkg::cdq_cmd_t               cmd,
    output cdq_pkg::cdq_status_t            status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [cdq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import cdq_pkg::*;

    // Control state
    logic [CAP_W-1:0] cap_reg;
    idx_t             head_reg, head_next;
    idx_t             tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic             ok_reg, ok_next;
    logic             m_valid_reg, m_valid_next;

    // Payload registers
    logic [ACT_W-1:0] act_reg;
    logic [VAL_W-1:0] din_reg;
    logic             out_ok_reg;
    logic [VAL_W-1:0] front_reg;
    logic [VAL_W-1:0] rear_reg;
    logic             out_empty_reg;
    logic             out_full_reg;

    cnt_t                  cap_eff;
    logic                  full_now;
    logic                  wr_en;
    idx_t                  wr_addr;
    logic [DATA_WIDTH-1:0] rd_data_a;
    logic [DATA_WIDTH-1:0] rd_data_b;

    // Clamp the capacity register into 1..DEPTH
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = cnt_t'(1);
        end else if (32'(cap_reg) > DEPTH) begin
            cap_eff = cnt_t'(DEPTH);
        end else begin
            cap_eff = cnt_t'(cap_reg);
        end
    end

    assign full_now = !empty_reg && (idx_next(tail_reg, cap_eff) == head_reg);

    // Apply one action to the indices and pick the store write
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        if (cmd.exec) begin
            ok_next = 1'b0;
            unique case (act_reg)
                ACT_QUERY: begin
                    ok_next = 1'b1;
                end
                ACT_INS_FRONT: begin
                    if (!full_now) begin
                        if (empty_reg) begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                        end else begin
                            head_next = idx_prev(head_reg, cap_eff);
                        end
                        wr_en   = 1'b1;
                        wr_addr = head_next;
                        ok_next = 1'b1;
                    end
                end
                ACT_INS_REAR: begin
                    if (!full_now) begin
                        if (empty_reg) begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                        end else begin
                            tail_next = idx_next(tail_reg, cap_eff);
                        end
                        wr_en   = 1'b1;
                        wr_addr = tail_next;
                        ok_next = 1'b1;
                    end
                end
                ACT_DEL_FRONT: begin
                    if (!empty_reg) begin
                        if (head_reg == tail_reg) begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end else begin
                            head_next = idx_next(head_reg, cap_eff);
                        end
                        ok_next = 1'b1;
                    end
                end
                ACT_DEL_REAR: begin
                    if (!empty_reg) begin
                        if (head_reg == tail_reg) begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end else begin
                            tail_next = idx_prev(tail_reg, cap_eff);
                        end
                        ok_next = 1'b1;
                    end
                end
                default: begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // Output valid: set on load, drop once the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers; a capacity write empties the deque
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_W'(CAP_RESET);
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg   <= cfg_wr_data;
                head_reg  <= '0;
                tail_reg  <= '0;
                empty_reg <= 1'b1;
            end else begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
        end
    end

    // Capture the input transfer and the result
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            act_reg <= s_tdata[ACT_W-1:0];
            din_reg <= s_tdata[ACT_W +: VAL_W];
        end
        if (cmd.load) begin
            out_ok_reg    <= ok_reg;
            front_reg     <= empty_reg ? '1 : VAL_W'(rd_data_a);
            rear_reg      <= empty_reg ? '1 : VAL_W'(rd_data_b);
            out_empty_reg <= empty_reg;
            out_full_reg  <= full_now;
        end
    end

    // Ring store, read at the head and the tail
    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk       (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (DATA_WIDTH'(din_reg)),
        .rd_addr_a (head_reg),
        .rd_addr_b (tail_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign status.out_busy = m_valid_reg && !m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_full_reg, out_empty_reg,
                      rear_reg, front_reg, out_ok_reg};

endmodule

[src/circular_deque_unit.sv]
// ============================================================================
// circular_deque_unit
// Double-ended queue over a ring store with a programmable capacity.
// ============================================================================
// Each input transfer carries an action (query, insert front, insert rear,
// delete front, delete rear) and a value, and yields exactly one result
// transfer: the success flag, the front and rear values after the action
// (all ones when the deque is empty) and the empty and full flags. One item
// is handled at a time, in steps: take, update indices and write the ring,
// registered ring read at head and tail, load the output register. The
// result load is held while the previous result still waits. The registered
// read of the ring store must follow the write. A new item is taken while
// the previous result still waits in the output register. Writing the
// capacity register (0 acts as 1, values above the ring depth act as the
// depth) empties the deque; it is to be written only while the block is
// idle. No clearing pass follows reset: only entries between head and tail
// are ever read.
module circular_deque_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]       cfg_wr_data,   // capacity
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] action, [34:3] data_in, [39:35] zero
    input  logic [cdq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] accepted, [32:1] front_value, [64:33] rear_value,
    // [65] is_empty, [66] is_full, [71:67] zero
    output logic [cdq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import cdq_pkg::*;

    cdq_cmd_t    cmd;
    cdq_status_t status;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    // One item in flight: no new transfer right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // Empty deque reports all ones at front and rear
    a_empty_values: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[65]) |->
            (m_tdata[32:1] == 32'hFFFF_FFFF && m_tdata[64:33] == 32'hFFFF_FFFF))
        else $error("empty result with stored values");

    // Empty and full never hold together
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[65] && m_tdata[66]))
        else $error("result both empty and full");

    // A result load follows each taken item
    a_load_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> ##3 (u_ctrl.state_reg == ST_LOAD))
        else $error("result load did not follow the taken item");
`endif

endmodule

[test/circular_deque_unit_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// circular_deque_unit_test
// Self-checking bench for the circular deque block: a directed table covers
// the empty and full cases, unknown actions, value extremes and capacity
// clamping, then random phases at several capacities fill and drain the
// deque under random stalls on both streams. Every result transfer is
// compared against an in-bench model of the deque or a typed-in result.
// ============================================================================
module circular_deque_unit_test;
    import cdq_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 2;
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 48;

    // Action codes the block does not know
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    localparam logic [VAL_W-1:0] NO_VALUE = '1;

    // One result, packed in the order of m_tdata from the top bit down
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [VAL_W-1:0] rear;
        logic [VAL_W-1:0] front;
        logic             accepted;
    } dq_result_t;

    localparam dq_result_t RES_EMPTY_OK = '{full: 1'b0, empty: 1'b1, rear: NO_VALUE,
                                            front: NO_VALUE, accepted: 1'b1};
    localparam dq_result_t RES_EMPTY_NO = '{full: 1'b0, empty: 1'b1, rear: NO_VALUE,
                                            front: NO_VALUE, accepted: 1'b0};
    localparam dq_result_t RES_NONE     = '0;

    typedef enum logic {
        ROW_ITEM,
        ROW_CAP
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;    // data_in, or the capacity for ROW_CAP
        logic             fixed;  // expected result typed in below
        dq_result_t       res;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{ROW_ITEM, ACT_QUERY,     32'h0,         1'b1, RES_EMPTY_OK},
        '{ROW_ITEM, ACT_DEL_FRONT, 32'h0,         1'b1, RES_EMPTY_NO},
        '{ROW_ITEM, ACT_DEL_REAR,  32'h0,         1'b1, RES_EMPTY_NO},
        '{ROW_ITEM, ACT_UNUSED_LO, 32'h0,         1'b1, RES_EMPTY_NO},
        '{ROW_ITEM, ACT_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, RES_EMPTY_NO},
        '{ROW_ITEM, ACT_INS_REAR,  32'h7FFF_FFFF, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_FRONT, 32'h8000_0000, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_REAR,  32'h0,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_FRONT, 32'hFFFF_FFFF, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_QUERY,     32'h0,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_UNUSED_HI, 32'h5555_5555, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_DEL_FRONT, 32'h0,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_DEL_REAR,  32'h0,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_DEL_FRONT, 32'h0,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_DEL_REAR,  32'h0,         1'b0, RES_NONE},
        '{ROW_CAP,  ACT_QUERY,     32'd1,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_FRONT, 32'h1234_5678, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_REAR,  32'hAAAA_AAAA, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_FRONT, 32'h5555_5555, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_DEL_REAR,  32'h0,         1'b0, RES_NONE},
        '{ROW_CAP,  ACT_QUERY,     32'd0,         1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_REAR,  32'hA5A5_A5A5, 1'b0, RES_NONE},
        '{ROW_ITEM, ACT_INS_REAR,  32'h5A5A_5A5A, 1'b0, RES_NONE},
        '{ROW_CAP,  ACT_QUERY,     32'd31,        1'b0, RES_NONE}
    };

    // Capacity per random phase; the last phase draws its own
    localparam logic [CAP_W-1:0] PHASE_CAP [0:PHASES-1] = '{
        5'd16, 5'd2, 5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd9, 5'd16, 5'd16
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Deque model state
    logic [VAL_W-1:0] dq_store [DEPTH];
    int               dq_head;
    int               dq_tail;
    bit               dq_empty;
    logic [CAP_W-1:0] dq_cap_reg;

    dq_result_t pending_results [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         no_idle = 1'b0;
    bit         hold_req = 1'b0;

    circular_deque_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // End the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int ring_cap();
        if (dq_cap_reg == '0) return 1;
        if (int'(dq_cap_reg) > DEPTH) return DEPTH;
        return int'(dq_cap_reg);
    endfunction

    function automatic int ring_next(int i, int cap);
        return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function automatic int ring_prev(int i, int cap);
        return (i == 0 || i >= cap) ? cap - 1 : i - 1;
    endfunction

    // Apply one action to the deque model and return the result it gives
    function automatic dq_result_t deque_apply(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val);
        dq_result_t res;
        int         cap;
        bit         full_now;
        cap = ring_cap();
        full_now = !dq_empty && (ring_next(dq_tail, cap) == dq_head);
        res = '0;
        case (act)
            ACT_QUERY: begin
                res.accepted = 1'b1;
            end
            ACT_INS_FRONT, ACT_INS_REAR: begin
                if (!full_now) begin
                    if (dq_empty) begin
                        dq_head = 0;
                        dq_tail = 0;
                        dq_empty = 1'b0;
                    end else if (act == ACT_INS_FRONT) begin
                        dq_head = ring_prev(dq_head, cap);
                    end else begin
                        dq_tail = ring_next(dq_tail, cap);
                    end
                    dq_store[(act == ACT_INS_FRONT) ? dq_head : dq_tail] = val;
                    res.accepted = 1'b1;
                end
            end
            ACT_DEL_FRONT, ACT_DEL_REAR: begin
                if (!dq_empty) begin
                    if (dq_head == dq_tail) begin
                        dq_head = 0;
                        dq_tail = 0;
                        dq_empty = 1'b1;
                    end else if (act == ACT_DEL_FRONT) begin
                        dq_head = ring_next(dq_head, cap);
                    end else begin
                        dq_tail = ring_prev(dq_tail, cap);
                    end
                    res.accepted = 1'b1;
                end
            end
            default: begin
                // unknown action: state untouched, refused
            end
        endcase
        res.empty = dq_empty;
        res.front = dq_empty ? NO_VALUE : dq_store[dq_head];
        res.rear  = dq_empty ? NO_VALUE : dq_store[dq_tail];
        res.full  = !dq_empty && (ring_next(dq_tail, cap) == dq_head);
        return res;
    endfunction

    // Offer one item after a random gap, hold it until the transfer, then
    // queue the expected result
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                             input bit fixed, input dq_result_t fixed_res);
        int         gap;
        dq_result_t res;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, val, act};
        do @(posedge aclk); while (!s_tready);
        res = deque_apply(act, val);
        pending_results.push_back(fixed ? fixed_res : res);
    endtask

    // Drain the block, then write the capacity register
    task automatic load_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        dq_cap_reg = cap;
        dq_head    = 0;
        dq_tail    = 0;
        dq_empty   = 1'b1;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        dq_result_t got;
        dq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[M_FIELDS_W-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (got.accepted !== want.accepted)
                        $display("%0t: accepted expected %0b actual %0b",
                                 $time, want.accepted, got.accepted);
                    if (got.front !== want.front)
                        $display("%0t: front_value expected %h actual %h",
                                 $time, want.front, got.front);
                    if (got.rear !== want.rear)
                        $display("%0t: rear_value expected %h actual %h",
                                 $time, want.rear, got.rear);
                    if (got.empty !== want.empty)
                        $display("%0t: is_empty expected %0b actual %0b",
                                 $time, want.empty, got.empty);
                    if (got.full !== want.full)
                        $display("%0t: is_full expected %0b actual %0b",
                                 $time, want.full, got.full);
                end
            end
        end
    end

    // Result side: random ready runs and stalls, one long hold-off on request
    initial begin : result_sink
        int run;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            run = no_idle ? 50 : $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Stimulus: directed table, then random phases over several capacities
    initial begin : stimulus
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic [CAP_W-1:0] cap;
        int               ins_pct;
        int               r;
        dq_head    = 0;
        dq_tail    = 0;
        dq_empty   = 1'b1;
        dq_cap_reg = CAP_W'(CAP_RESET);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].kind == ROW_CAP) begin
                load_capacity(DIR_TAB[i].val[CAP_W-1:0]);
            end else begin
                send_item(DIR_TAB[i].act, DIR_TAB[i].val, DIR_TAB[i].fixed, DIR_TAB[i].res);
            end
        end
        // Capacity write must leave the deque empty
        send_item(ACT_QUERY, '0, 1'b1, RES_EMPTY_OK);

        for (int ph = 0; ph < PHASES; ph++) begin
            cap = (ph == PHASES - 1) ? CAP_W'($urandom_range(0, 31)) : PHASE_CAP[ph];
            load_capacity(cap);
            no_idle = (ph == 6);
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            // Fill in the first half, drain in the second
            ins_pct = $urandom_range(70, 90);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    ins_pct = 100 - ins_pct;
                end
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
                end else if (r < 10) begin
                    act = ACT_QUERY;
                end else if ($urandom_range(0, 99) < ins_pct) begin
                    act = $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_REAR;
                end else begin
                    act = $urandom_range(0, 1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
                end
                case ($urandom_range(0, 15))
                    0:       val = '0;
                    1:       val = '1;
                    2:       val = 32'h7FFF_FFFF;
                    3:       val = 32'h8000_0000;
                    default: val = $urandom();
                endcase
                send_item(act, val, 1'b0, RES_NONE);
            end
        end
        no_idle = 1'b0;

        // Drain and report
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
